FILE: hdl/rcpc_pkg.sv
// shared types, constants and the divide-by-1000 digit step for the pwm capture block
package rcpc_pkg;

   // time and millisecond widths
   localparam int unsigned TIME_W      = 48;
   localparam int unsigned MS_W        = 39;
   localparam int unsigned US_PER_MS   = 1000;
   localparam int unsigned DIGIT_W     = 4;
   localparam int unsigned STEPS_STAGE = 2;
   localparam int unsigned DIV_STAGES  = TIME_W / (DIGIT_W * STEPS_STAGE);
   localparam int unsigned REM_W       = 10;

   // item codes
   typedef enum logic {
      FUNC_EDGE  = 1'b0,
      FUNC_QUERY = 1'b1
   } func_type;

   // register indexes of the csr port
   typedef enum logic [2:0] {
      CSR_FILTER_MIN = 3'd0,
      CSR_FILTER_MAX = 3'd1,
      CSR_VALID_MIN  = 3'd2,
      CSR_VALID_MAX  = 3'd3,
      CSR_TIMEOUT    = 3'd4,
      CSR_NEUTRAL    = 3'd5
   } csr_index_type;

   // configuration values seen by the channel core
   typedef struct packed {
      logic [15:0] filter_min_us;
      logic [15:0] filter_max_us;
      logic [11:0] valid_min_us;
      logic [11:0] valid_max_us;
      logic [15:0] timeout_ms;
      logic [11:0] neutral_us;
   } cfg_type;

   // one input transaction
   typedef struct packed {
      func_type          func;
      logic [2:0]        channel;
      logic              pin_level;
      logic [TIME_W-1:0] time_us;
   } item_type;

   // item travelling down the divider pipeline
   typedef struct packed {
      item_type          item;
      logic [REM_W-1:0]  rem;
      logic [TIME_W-1:0] quot;
      logic [TIME_W-1:0] pend;
   } div_type;

   // result of one long-division digit step
   typedef struct packed {
      logic [DIGIT_W-1:0] digit;
      logic [REM_W-1:0]   rem;
   } step_type;

   // one radix-16 digit of the division by 1000
   function automatic step_type div_step(input logic [REM_W-1:0] rem,
                                         input logic [DIGIT_W-1:0] nib);
      logic [13:0]        r;
      logic [13:0]        sub;
      logic [DIGIT_W-1:0] d;
      step_type           res;
      int                 i;
      r = {rem, nib};
      d = '0;
      // multiples of 1000 rise monotonically, so the last hit is the digit
      for (i = 1; i < 16; i++) begin
         if (r >= 14'(i * US_PER_MS)) begin
            d = 4'(i);
         end
      end
      sub       = r - 14'(d) * 14'(US_PER_MS);
      res.digit = d;
      res.rem   = sub[REM_W-1:0];
      return res;
   endfunction

endpackage

FILE: hdl/rcpc_csr.sv
// configuration register bank of the pwm capture block
module rcpc_csr (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [2:0]              csr_index,
   input  logic [15:0]             csr_wdata,
   output rcpc_pkg::cfg_type       cfg
);
   import rcpc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // writes are always taken
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // next register values
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FILTER_MIN: cfg_in.filter_min_us = csr_wdata;
            CSR_FILTER_MAX: cfg_in.filter_max_us = csr_wdata;
            CSR_VALID_MIN:  cfg_in.valid_min_us  = csr_wdata[11:0];
            CSR_VALID_MAX:  cfg_in.valid_max_us  = csr_wdata[11:0];
            CSR_TIMEOUT:    cfg_in.timeout_ms    = csr_wdata;
            CSR_NEUTRAL:    cfg_in.neutral_us    = csr_wdata[11:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   // register bank with reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.filter_min_us <= 16'd300;
         cfg_ff.filter_max_us <= 16'd30000;
         cfg_ff.valid_min_us  <= 12'd900;
         cfg_ff.valid_max_us  <= 12'd2100;
         cfg_ff.timeout_ms    <= 16'd200;
         cfg_ff.neutral_us    <= 12'd1500;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: hdl/rcpc_div_stage.sv
// one stage of the microsecond to millisecond divider pipeline, two digits per stage
module rcpc_div_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  rcpc_pkg::div_type   d_in,
   output logic                out_valid,
   output rcpc_pkg::div_type   d_out
);
   import rcpc_pkg::*;

   logic     valid_ff;
   div_type  d_ff;
   div_type  d_in_next;
   step_type step_a;
   step_type step_b;

   // two dependent digit steps on the top byte of the pending time
   always_comb begin
      step_a               = div_step(d_in.rem, d_in.pend[TIME_W-1 -: DIGIT_W]);
      step_b               = div_step(step_a.rem,
                                      d_in.pend[TIME_W-1-DIGIT_W -: DIGIT_W]);
      d_in_next.item       = d_in.item;
      d_in_next.rem        = step_b.rem;
      d_in_next.quot       = {d_in.quot[TIME_W-1-2*DIGIT_W:0], step_a.digit, step_b.digit};
      d_in_next.pend       = {d_in.pend[TIME_W-1-2*DIGIT_W:0], {(2*DIGIT_W){1'b0}}};
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff <= d_in_next;
      end
   end

   assign out_valid = valid_ff;
   assign d_out     = d_ff;

endmodule

FILE: hdl/rcpc_chan_core.sv
// per-channel capture state, width measurement and status result register
module rcpc_chan_core #(
   parameter int CHANNELS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  rcpc_pkg::div_type   d_in,
   input  rcpc_pkg::cfg_type   cfg,
   output logic                rsp_valid,
   output logic [2:0]          rsp_out_channel,
   output logic [11:0]         rsp_pulse_width_us,
   output logic                rsp_sample_taken,
   output logic                rsp_has_update,
   output logic [15:0]         rsp_age_ms,
   output logic                rsp_fresh
);
   import rcpc_pkg::*;

   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // channel state
   logic [TIME_W-1:0] rise_ff  [CHANNELS];
   logic [11:0]       width_ff [CHANNELS];
   logic [MS_W-1:0]   upd_ff   [CHANNELS];
   logic [CHANNELS-1:0] seen_ff;
   logic [CHANNELS-1:0] valid_ff;

   // result registers
   logic        rsp_valid_ff;
   logic [2:0]  out_channel_ff;
   logic [11:0] width_out_ff;
   logic        taken_ff;
   logic        known_ff;
   logic [15:0] age_ff;
   logic        fresh_ff;

   logic [2:0]  out_channel_in;
   logic [11:0] width_out_in;
   logic        taken_in;
   logic        known_in;
   logic [15:0] age_in;
   logic        fresh_in;

   // write values and enables
   logic [TIME_W-1:0] rise_in;
   logic [11:0]       width_in;
   logic [MS_W-1:0]   upd_in;
   logic              rise_we;
   logic              fall_we;

   logic [4:0]          ch_ext;
   logic [CH_IDX_W-1:0] idx;
   logic                in_range;
   logic                is_edge;
   logic [TIME_W-1:0]   now;
   logic [MS_W-1:0]     now_ms;
   logic [TIME_W-1:0]   rise_rd;
   logic                seen_rd;
   logic                valid_rd;
   logic [11:0]         width_rd;
   logic [MS_W-1:0]     upd_rd;
   logic [TIME_W-1:0]   meas;
   logic                meas_ok;
   logic                meas_narrow;
   logic                in_filter;
   logic                in_window;
   logic                valid_a;
   logic [MS_W-1:0]     upd_a;
   logic [11:0]         width_a;
   logic [MS_W-1:0]     diff;
   logic                non_neg;

   // channel decode and state read
   always_comb begin
      ch_ext   = {2'b00, d_in.item.channel};
      in_range = ch_ext < 5'(CHANNELS);
      idx      = ch_ext[CH_IDX_W-1:0];
      now      = d_in.item.time_us;
      now_ms   = d_in.quot[MS_W-1:0];
      is_edge  = in_range && (d_in.item.func == FUNC_EDGE);
      rise_rd  = rise_ff[idx];
      seen_rd  = seen_ff[idx];
      valid_rd = valid_ff[idx];
      width_rd = width_ff[idx];
      upd_rd   = upd_ff[idx];
   end

   // edge handling and width measurement
   always_comb begin
      rise_we     = is_edge && d_in.item.pin_level;
      fall_we     = is_edge && !d_in.item.pin_level && seen_rd;
      rise_in     = now;
      meas        = now - rise_rd;
      meas_ok     = (rise_rd != '0) && (now > rise_rd);
      meas_narrow = meas[TIME_W-1:16] == '0;
      in_filter   = meas_narrow && (meas[15:0] >= cfg.filter_min_us)
                    && (meas[15:0] <= cfg.filter_max_us);
      in_window   = meas_narrow && (meas[15:0] >= {4'b0000, cfg.valid_min_us})
                    && (meas[15:0] <= {4'b0000, cfg.valid_max_us});
      taken_in    = fall_we && meas_ok && in_filter && in_window;
      width_in    = meas[11:0];
      upd_in      = now_ms;
   end

   // channel status after this transaction
   always_comb begin
      valid_a        = valid_rd || taken_in;
      upd_a          = taken_in ? upd_in : upd_rd;
      width_a        = taken_in ? width_in : width_rd;
      diff           = now_ms - upd_a;
      non_neg        = now_ms >= upd_a;
      out_channel_in = d_in.item.channel;
      width_out_in   = cfg.neutral_us;
      known_in       = 1'b0;
      age_in         = '0;
      fresh_in       = 1'b0;
      if (in_range) begin
         known_in = upd_a != '0;
         if (valid_a) begin
            width_out_in = width_a;
         end
         if (known_in && non_neg) begin
            age_in   = (diff[MS_W-1:16] != '0) ? 16'hFFFF : diff[15:0];
            fresh_in = valid_a && (diff <= {{(MS_W-16){1'b0}}, cfg.timeout_ms});
         end
      end
   end

   // state write, control bits reset
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= '0;
         valid_ff <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            upd_ff[i] <= '0;
         end
      end else if (adv && in_valid) begin
         if (rise_we) begin
            seen_ff[idx] <= 1'b1;
         end else if (fall_we) begin
            seen_ff[idx] <= 1'b0;
         end
         if (taken_in) begin
            valid_ff[idx] <= 1'b1;
            upd_ff[idx]   <= upd_in;
         end
      end
   end

   // payload state
   always_ff @(posedge clock) begin
      if (adv && in_valid) begin
         if (rise_we) begin
            rise_ff[idx] <= rise_in;
         end
         if (taken_in) begin
            width_ff[idx] <= width_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_channel_ff <= out_channel_in;
         width_out_ff   <= width_out_in;
         taken_ff       <= taken_in;
         known_ff       <= known_in;
         age_ff         <= age_in;
         fresh_ff       <= fresh_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_channel    = out_channel_ff;
   assign rsp_pulse_width_us = width_out_ff;
   assign rsp_sample_taken   = taken_ff;
   assign rsp_has_update     = known_ff;
   assign rsp_age_ms         = age_ff;
   assign rsp_fresh          = fresh_ff;

endmodule

FILE: hdl/rc_pwm_pulse_capture.sv
// top level of the multi-channel rc servo pwm pulse width capture block
//
// req_ channel: one transaction is either a pin edge (req_func 0, with the
// new pin level) or a status query (req_func 1) for req_channel, stamped
// with a free-running microsecond time. every transaction gives exactly
// one rsp_ transaction with the channel's stored width (neutral if none),
// whether this edge took a new sample, whether the update time is known,
// the sample age in milliseconds and whether the channel is valid now.
// csr_ channel: register index and data, always ready; write it only while
// no transaction is in flight.
// throughput is one transaction per cycle while the pipeline is not held.
// a transaction passes the six-stage divide-by-1000 pipeline, which turns
// the microsecond time into milliseconds ahead of the channel state update,
// and then the result register that drives rsp_valid.
// when rsp_ready is low while a result is waiting, the whole pipeline holds
// and req_ready drops; nothing is lost.
// synchronous reset clears the pipeline, the registers to their defaults and
// every channel to "no sample, no rise seen".
module rc_pwm_pulse_capture #(
   parameter int CHANNELS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [2:0]  req_channel,
   input  logic        req_pin_level,
   input  logic [47:0] req_time_us,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_out_channel,
   output logic [11:0] rsp_pulse_width_us,
   output logic        rsp_sample_taken,
   output logic        rsp_has_update,
   output logic [15:0] rsp_age_ms,
   output logic        rsp_fresh,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import rcpc_pkg::*;

   cfg_type           cfg;
   logic              adv;
   logic [DIV_STAGES:0] stg_v;
   div_type           stg_d [DIV_STAGES+1];

   // the pipeline moves whenever the result register is free or being taken
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // request enters the divider with an empty remainder
   assign stg_v[0]             = req_valid;
   assign stg_d[0].item.func      = func_type'(req_func);
   assign stg_d[0].item.channel   = req_channel;
   assign stg_d[0].item.pin_level = req_pin_level;
   assign stg_d[0].item.time_us   = req_time_us;
   assign stg_d[0].rem            = '0;
   assign stg_d[0].quot           = '0;
   assign stg_d[0].pend           = req_time_us;

   rcpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // divide-by-1000 pipeline
   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      rcpc_div_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (stg_v[s]),
         .d_in      (stg_d[s]),
         .out_valid (stg_v[s+1]),
         .d_out     (stg_d[s+1])
      );
   end

   rcpc_chan_core #(
      .CHANNELS (CHANNELS)
   ) u_core (
      .clock              (clock),
      .reset              (reset),
      .adv                (adv),
      .in_valid           (stg_v[DIV_STAGES]),
      .d_in               (stg_d[DIV_STAGES]),
      .cfg                (cfg),
      .rsp_valid          (rsp_valid),
      .rsp_out_channel    (rsp_out_channel),
      .rsp_pulse_width_us (rsp_pulse_width_us),
      .rsp_sample_taken   (rsp_sample_taken),
      .rsp_has_update     (rsp_has_update),
      .rsp_age_ms         (rsp_age_ms),
      .rsp_fresh          (rsp_fresh)
   );

endmodule
